/* rtl/lfu_cache_lru_tiebreak_macros.svh */
// Assertion macros shared by the cache RTL.
`ifndef LFU_CACHE_LRU_TIEBREAK_MACROS_SVH
`define LFU_CACHE_LRU_TIEBREAK_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication.
`define LFUC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lfuc assertion failed");
// Next-cycle implication.
`define LFUC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lfuc assertion failed");
`else
`define LFUC_ASSERT_IMP(label, clk, rst, ante, cons)
`define LFUC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/lfuc_pkg.sv */
// Shared types and constants for the LFU cache.
package lfuc_pkg;

   localparam int CAPACITY_DEFAULT = 16;

   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;
   localparam int COUNT_W = 16;
   localparam int STAMP_W = 64;
   localparam int CAP_W   = 5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // csr space: one register, byte addressed
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_CAPACITY_IN_USE = 1'b0;

   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_PUT = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [VAL_W-1:0]   value;
      logic [COUNT_W-1:0] count;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic clear;
      logic sample;
   } scan_ctrl_type;

   typedef struct packed {
      logic match_found;
      logic victim_found;
   } scan_flags_type;

endpackage

/* rtl/lfuc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lfuc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lfuc_scan.sv */
// Per-entry compare unit: key match and LFU/oldest-stamp victim tracking.
module lfuc_scan import lfuc_pkg::*; #(
   parameter int IDX_W = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  scan_ctrl_type    ctrl,
   input  logic [KEY_W-1:0] key,
   input  logic [IDX_W-1:0] idx,
   input  entry_type        entry,
   output scan_flags_type   flags,
   output logic [IDX_W-1:0] match_idx,
   output entry_type        match_entry,
   output logic [IDX_W-1:0] vict_idx,
   output logic [KEY_W-1:0] vict_key
);

   scan_flags_type     flags_ff, flags_in;
   logic [IDX_W-1:0]   match_idx_ff, match_idx_in;
   entry_type          match_entry_ff, match_entry_in;
   logic [IDX_W-1:0]   vict_idx_ff, vict_idx_in;
   logic [KEY_W-1:0]   vict_key_ff, vict_key_in;
   logic [COUNT_W-1:0] vict_count_ff, vict_count_in;
   logic [STAMP_W-1:0] vict_stamp_ff, vict_stamp_in;
   logic               is_match;
   logic               is_better;

   assign is_match  = (entry.key == key);
   // lower count wins, then older stamp
   assign is_better = !flags_ff.victim_found ||
                      ({entry.count, entry.stamp} < {vict_count_ff, vict_stamp_ff});

   always_comb begin
      flags_in       = flags_ff;
      match_idx_in   = match_idx_ff;
      match_entry_in = match_entry_ff;
      vict_idx_in    = vict_idx_ff;
      vict_key_in    = vict_key_ff;
      vict_count_in  = vict_count_ff;
      vict_stamp_in  = vict_stamp_ff;
      if (ctrl.clear) begin
         flags_in = '0;
      end else if (ctrl.sample) begin
         if (is_match) begin
            flags_in.match_found = 1'b1;
            match_idx_in         = idx;
            match_entry_in       = entry;
         end
         if (is_better) begin
            flags_in.victim_found = 1'b1;
            vict_idx_in           = idx;
            vict_key_in           = entry.key;
            vict_count_in         = entry.count;
            vict_stamp_in         = entry.stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      match_idx_ff   <= match_idx_in;
      match_entry_ff <= match_entry_in;
      vict_idx_ff    <= vict_idx_in;
      vict_key_ff    <= vict_key_in;
      vict_count_ff  <= vict_count_in;
      vict_stamp_ff  <= vict_stamp_in;
   end

   assign flags       = flags_ff;
   assign match_idx   = match_idx_ff;
   assign match_entry = match_entry_ff;
   assign vict_idx    = vict_idx_ff;
   assign vict_key    = vict_key_ff;

endmodule

/* rtl/lfu_cache_lru_tiebreak.sv */
// LFU key-value cache top level: sequencer, entry RAM, scan unit, csr and result beat.
//
// Fully associative cache of up to CAPACITY entries, LFU replacement with
// oldest-stamp tie-break. Request beats (req_*) carry a get or put of a
// 32-bit key; each request yields exactly one response beat (rsp_*).
// Occupied entries always form a prefix of the RAM (slots 0..occupancy-1),
// so no per-entry valid bits are kept: the fill count marks them.
// Per request the sequencer reads every occupied entry once from the entry
// RAM (one read port, one entry per cycle) through one compare unit, then
// does at most one write-back.
// req_tready is high only while the sequencer is idle. The response sits in
// an output register, so the next request is accepted while it waits; a
// stalled rsp_tready holds the finished result of the following request
// until the register frees up.
// Reset empties the cache, zeroes the stamp counter and sets
// capacity_in_use to min(CAPACITY, 16). The csr port (capacity_in_use at
// byte address 0) ignores writes while the cache holds entries; values
// above CAPACITY are clamped.
`include "lfu_cache_lru_tiebreak_macros.svh"

module lfu_cache_lru_tiebreak import lfuc_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [63:0]           req_tdata,   // [31:0] key, [63:32] value
   input  logic [0:0]            req_tuser,   // [0] mode (0 get, 1 put)
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata,   // [31:0] read_value, [63:32] evicted_key
   output logic [1:0]            rsp_tuser,   // [0] hit, [1] evicted
   // csr port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OCC_W = $clog2(CAPACITY + 1);
   localparam logic [CAP_W-1:0] CAP_RESET =
      (CAPACITY < 16) ? CAP_W'(CAPACITY) : CAP_W'(16);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DECIDE = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic [OCC_W-1:0]   issue_ff, issue_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;

   // latched request
   logic               mode_ff, mode_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VAL_W-1:0]   val_ff, val_in;

   // finished result waiting for the output register
   logic               res_hit_ff, res_hit_in;
   logic [VAL_W-1:0]   res_rd_ff, res_rd_in;
   logic               res_ev_ff, res_ev_in;
   logic [KEY_W-1:0]   res_evk_ff, res_evk_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_data_ff, rsp_data_in;
   logic [1:0]         rsp_user_ff, rsp_user_in;

   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   entry_type          ram_wdata;
   entry_type          ram_rdata;

   scan_ctrl_type      scan_ctrl;
   scan_flags_type     scan_flags;
   logic [IDX_W-1:0]   match_idx;
   entry_type          match_entry;
   logic [IDX_W-1:0]   vict_idx;
   logic [KEY_W-1:0]   vict_key;

   logic               req_beat;
   logic               csr_wr;
   logic [CAP_W-1:0]   csr_wval;
   logic               cache_full;
   logic               rsp_free;
   entry_type          upd_entry;
   logic               count_sat;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // ---------------- csr ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == REG_CAPACITY_IN_USE);
   assign csr_wval   = csr_pwdata[CAP_W-1:0];

   always_comb begin
      cap_in = cap_ff;
      if (csr_wr && (occ_ff == '0)) begin
         cap_in = (32'(csr_wval) > CAPACITY) ? CAP_W'(CAPACITY) : csr_wval;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_CAPACITY_IN_USE) ?
                       CSR_DATA_W'(cap_ff) : '0;

   // ---------------- entry storage ----------------
   lfuc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   lfuc_scan #(
      .IDX_W (IDX_W)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (scan_ctrl),
      .key         (key_ff),
      .idx         (cmp_idx_ff),
      .entry       (ram_rdata),
      .flags       (scan_flags),
      .match_idx   (match_idx),
      .match_entry (match_entry),
      .vict_idx    (vict_idx),
      .vict_key    (vict_key)
   );

   assign scan_ctrl.clear  = req_beat;
   assign scan_ctrl.sample = (state_ff == ST_SCAN) && cmp_valid_ff;

   // ---------------- sequencer ----------------
   assign cache_full = (32'(occ_ff) >= 32'(cap_ff));
   assign count_sat  = (match_entry.count == COUNT_MAX);

   always_comb begin
      upd_entry = match_entry;
      if (!count_sat) begin
         upd_entry.count = match_entry.count + 16'd1;
         upd_entry.stamp = stamp_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      stamp_in     = stamp_ff;
      issue_in     = issue_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      res_hit_in   = res_hit_ff;
      res_rd_in    = res_rd_ff;
      res_ev_in    = res_ev_ff;
      res_evk_in   = res_evk_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      ram_we       = 1'b0;
      ram_waddr    = match_idx;
      ram_wdata    = upd_entry;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            issue_in = '0;
            if (req_beat) begin
               mode_in  = req_tuser[0];
               key_in   = req_tdata[31:0];
               val_in   = req_tdata[63:32];
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // one read issued per cycle, compared in the next cycle
            if (issue_ff != occ_ff) begin
               cmp_valid_in = 1'b1;
               cmp_idx_in   = issue_ff[IDX_W-1:0];
               issue_in     = issue_ff + OCC_W'(1);
            end else if (!cmp_valid_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            res_hit_in = 1'b0;
            res_rd_in  = '0;
            res_ev_in  = 1'b0;
            res_evk_in = '0;
            if (mode_ff == MODE_GET) begin
               if (scan_flags.match_found) begin
                  res_hit_in = 1'b1;
                  res_rd_in  = match_entry.value;
                  if (!count_sat) begin
                     ram_we   = 1'b1;
                     stamp_in = stamp_ff + 64'd1;
                  end
               end
            end else if (cap_ff != '0) begin
               if (scan_flags.match_found) begin
                  res_hit_in      = 1'b1;
                  ram_we          = 1'b1;
                  ram_wdata.value = val_ff;
                  if (!count_sat) begin
                     stamp_in = stamp_ff + 64'd1;
                  end
               end else begin
                  // insert: reuse the victim slot when full, else extend the prefix
                  ram_we          = 1'b1;
                  ram_wdata.key   = key_ff;
                  ram_wdata.value = val_ff;
                  ram_wdata.count = 16'd1;
                  ram_wdata.stamp = stamp_ff;
                  stamp_in        = stamp_ff + 64'd1;
                  if (cache_full) begin
                     res_ev_in  = 1'b1;
                     res_evk_in = vict_key;
                     ram_waddr  = vict_idx;
                  end else begin
                     ram_waddr = occ_ff[IDX_W-1:0];
                     occ_in    = occ_ff + OCC_W'(1);
                  end
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_evk_ff, res_rd_ff};
               rsp_user_in  = {res_ev_ff, res_hit_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         occ_ff       <= '0;
         stamp_ff     <= '0;
         issue_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         occ_ff       <= occ_in;
         stamp_ff     <= stamp_in;
         issue_ff     <= issue_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff  <= cmp_idx_in;
      mode_ff     <= mode_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      res_hit_ff  <= res_hit_in;
      res_rd_ff   <= res_rd_in;
      res_ev_ff   <= res_ev_in;
      res_evk_ff  <= res_evk_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // ---------------- checks ----------------
   // fill count never passes the configured capacity
   `LFUC_ASSERT_IMP(a_occ_le_cap, clock, reset, 1'b1, 32'(occ_ff) <= 32'(cap_ff))
   // capacity is frozen while the cache holds entries
   `LFUC_ASSERT_NXT(a_cap_frozen, clock, reset, occ_ff != '0, $stable(cap_ff))
   // a put miss into a full cache always has a victim from the scan
   `LFUC_ASSERT_IMP(a_victim_found, clock, reset, (state_ff == ST_DECIDE) && (mode_ff == MODE_PUT) && (cap_ff != '0) && !scan_flags.match_found && cache_full, scan_flags.victim_found)
   // fill count moves only at write-back
   `LFUC_ASSERT_NXT(a_occ_only_decide, clock, reset, state_ff != ST_DECIDE, $stable(occ_ff))

endmodule
